@@ sv/kpi_pkg.sv @@
// shared constants and helpers for the k-mer position index
package kpi_pkg;

    localparam logic [1:0] MODE_BEGIN = 2'd0;
    localparam logic [1:0] MODE_BASE  = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    localparam logic [7:0] CH_A_UP = 8'h41;
    localparam logic [7:0] CH_C_UP = 8'h43;
    localparam logic [7:0] CH_G_UP = 8'h47;
    localparam logic [7:0] CH_T_UP = 8'h54;
    localparam logic [7:0] CH_A_LO = 8'h61;
    localparam logic [7:0] CH_C_LO = 8'h63;
    localparam logic [7:0] CH_G_LO = 8'h67;
    localparam logic [7:0] CH_T_LO = 8'h74;

    localparam logic [1:0] CODE_A = 2'd0;
    localparam logic [1:0] CODE_C = 2'd1;
    localparam logic [1:0] CODE_G = 2'd2;
    localparam logic [1:0] CODE_T = 2'd3;

    localparam logic [2:0] WSIZE_RESET = 3'd6;

    // build generation tag kept next to each bucket count
    localparam int EPOCH_W = 4;

    typedef struct packed {
        logic       ok;
        logic [1:0] code;
    } t_base;

    function automatic t_base kpi_base_code(input logic [7:0] ch);
        t_base r;
        r.ok   = 1'b1;
        r.code = CODE_A;
        case (ch) inside
            CH_A_UP, CH_A_LO: r.code = CODE_A;
            CH_C_UP, CH_C_LO: r.code = CODE_C;
            CH_G_UP, CH_G_LO: r.code = CODE_G;
            CH_T_UP, CH_T_LO: r.code = CODE_T;
            default:          r.ok   = 1'b0;
        endcase
        return r;
    endfunction

endpackage

@@ sv/kpi_if.sv @@
// valid/ready channel interfaces for items and results
interface kpi_in_if #(
    parameter int BW = 12,
    parameter int SW = 4
);
    logic          valid;
    logic          ready;
    logic [1:0]    mode;
    logic [7:0]    base_char;
    logic [31:0]   start_location;
    logic [BW-1:0] query_bucket;
    logic [SW-1:0] query_slot;

    modport source (output valid, mode, base_char, start_location, query_bucket, query_slot,
                    input ready);
    modport sink   (input valid, mode, base_char, start_location, query_bucket, query_slot,
                    output ready);
endinterface

interface kpi_out_if #(
    parameter int CW = 5
);
    logic          valid;
    logic          ready;
    logic [CW-1:0] bucket_count;
    logic [31:0]   slot_location;
    logic          slot_valid;

    modport source (output valid, bucket_count, slot_location, slot_valid, input ready);
    modport sink   (input valid, bucket_count, slot_location, slot_valid, output ready);
endinterface

@@ sv/kmer_position_index_core.sv @@
// k-mer position index: bucket count memory plus location memory with read-modify-write
// Builds a table of window locations keyed by the 2-bit-encoded k-mer of a nucleotide stream.
// Counts and locations live in two synchronous memories with a registered read. A base byte that
// completes a window reads its count in S_IDLE, then writes count and location in S_WB; a base
// byte that completes no window and a begin finish in S_IDLE; a query reads in S_IDLE, then waits
// in S_WB for the output register to drain; no item is accepted outside S_IDLE. Each count
// entry carries a build tag, so a begin does not touch the memory; only when the tag wraps, and
// once after reset, a clearing pass walks all 4^MAX_K count entries (4096 at the defaults).
module kmer_position_index_core
    import kpi_pkg::*;
#(
    parameter int MAX_K = 6,
    parameter int SLOTS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_wdata,
    kpi_in_if.sink           i_item,
    kpi_out_if.source        o_res
);

    localparam int BW       = 2 * MAX_K;
    localparam int NBUCKETS = 1 << BW;
    localparam int SW       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW       = $clog2(SLOTS + 2);
    localparam int OW       = $clog2(SLOTS + 1);
    localparam int AW       = (NBUCKETS * SLOTS > 1) ? $clog2(NBUCKETS * SLOTS) : 1;
    localparam int RW       = $clog2(MAX_K + 1);
    localparam int EW       = EPOCH_W + CW;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_WB    = 3'b010,
        S_CLEAR = 3'b100
    } t_state;

    // memories
    logic [EW-1:0] cnt_mem [NBUCKETS];
    logic [31:0]   loc_mem [NBUCKETS * SLOTS];
    logic [EW-1:0] r_cnt_rd;
    logic [31:0]   r_loc_rd;

    logic          w_cnt_re, w_cnt_we, w_loc_re, w_loc_we;
    logic [BW-1:0] w_cnt_raddr, w_cnt_waddr;
    logic [EW-1:0] w_cnt_wdata;
    logic [AW-1:0] w_loc_raddr, w_loc_waddr;
    logic [31:0]   w_loc_wdata;

    // control and payload registers
    t_state         r_state, n_state;
    logic [2:0]     r_wsize;
    logic [EPOCH_W-1:0] r_epoch, n_epoch;
    logic [BW-1:0]  r_code, n_code;
    logic [RW-1:0]  r_run, n_run;
    logic [31:0]    r_nloc, n_nloc;
    logic [BW-1:0]  r_clr, n_clr;
    logic           r_is_query, n_is_query;
    logic [BW-1:0]  r_bucket, n_bucket;
    logic [31:0]    r_loc, n_loc;
    logic [SW-1:0]  r_qslot, n_qslot;
    logic           r_qin, n_qin;
    logic           r_ovalid, n_ovalid;
    logic [OW-1:0]  r_ocount, n_ocount;
    logic [31:0]    r_oloc, n_oloc;
    logic           r_oslot, n_oslot;

    logic           w_accept;
    logic [RW-1:0]  w_k;
    logic [BW-1:0]  w_kmask;
    t_base          w_base;
    logic [BW-1:0]  w_next_code;
    logic [RW-1:0]  w_next_run;
    logic           w_hit;
    logic [CW-1:0]  w_cnt;
    logic [CW-1:0]  w_qcnt;
    logic           w_out_busy;

    assign i_item.ready       = (r_state == S_IDLE);
    assign w_accept           = i_item.valid && i_item.ready;
    assign o_res.valid        = r_ovalid;
    assign o_res.bucket_count = r_ocount;
    assign o_res.slot_location = r_oloc;
    assign o_res.slot_valid   = r_oslot;
    assign w_out_busy         = r_ovalid && !o_res.ready;

    // effective window length, clamped to 1..MAX_K
    always_comb begin
        if (r_wsize == 3'd0) begin
            w_k = RW'(1);
        end else if (int'(r_wsize) > MAX_K) begin
            w_k = RW'(MAX_K);
        end else begin
            w_k = RW'(r_wsize);
        end
    end

    assign w_kmask     = ~({BW{1'b1}} << {w_k, 1'b0});
    assign w_base      = kpi_base_code(i_item.base_char);
    assign w_next_code = BW'({r_code, w_base.code});
    assign w_next_run  = (int'(r_run) < MAX_K) ? RW'(r_run + 1'b1) : r_run;
    assign w_hit       = w_base.ok && (w_next_run >= w_k);

    // stale tag means the bucket was not touched in this build
    assign w_cnt  = (r_cnt_rd[EW-1 -: EPOCH_W] == r_epoch) ? r_cnt_rd[CW-1:0] : '0;
    assign w_qcnt = (r_qin && (int'(w_cnt) <= SLOTS)) ? w_cnt : '0;

    always_comb begin
        n_state    = r_state;
        n_epoch    = r_epoch;
        n_code     = r_code;
        n_run      = r_run;
        n_nloc     = r_nloc;
        n_clr      = r_clr;
        n_is_query = r_is_query;
        n_bucket   = r_bucket;
        n_loc      = r_loc;
        n_qslot    = r_qslot;
        n_qin      = r_qin;
        n_ovalid   = r_ovalid && !o_res.ready;
        n_ocount   = r_ocount;
        n_oloc     = r_oloc;
        n_oslot    = r_oslot;

        w_cnt_re    = 1'b0;
        w_cnt_raddr = '0;
        w_cnt_we    = 1'b0;
        w_cnt_waddr = r_bucket;
        w_cnt_wdata = {r_epoch, CW'(w_cnt + 1'b1)};
        w_loc_re    = 1'b0;
        w_loc_raddr = '0;
        w_loc_we    = 1'b0;
        w_loc_waddr = AW'(AW'(r_bucket) * AW'(SLOTS) + AW'(w_cnt));
        w_loc_wdata = r_loc;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_item.mode == MODE_BEGIN) begin
                        n_code = '0;
                        n_run  = '0;
                        n_nloc = i_item.start_location;
                        if (r_epoch == '1) begin
                            n_epoch = '0;
                            n_clr   = '0;
                            n_state = S_CLEAR;
                        end else begin
                            n_epoch = r_epoch + 1'b1;
                        end
                    end else if (i_item.mode == MODE_BASE) begin
                        n_nloc = r_nloc + 32'd1;
                        if (w_base.ok) begin
                            n_code = w_next_code;
                            n_run  = w_next_run;
                        end else begin
                            n_run  = '0;
                        end
                        if (w_hit) begin
                            n_is_query  = 1'b0;
                            n_bucket    = w_next_code & w_kmask;
                            n_loc       = r_nloc - 32'(w_k - 1'b1);
                            w_cnt_re    = 1'b1;
                            w_cnt_raddr = w_next_code & w_kmask;
                            n_state     = S_WB;
                        end
                    end else if (i_item.mode == MODE_QUERY) begin
                        n_is_query  = 1'b1;
                        n_qslot     = i_item.query_slot;
                        n_qin       = ((i_item.query_bucket & ~w_kmask) == '0);
                        w_cnt_re    = 1'b1;
                        w_cnt_raddr = i_item.query_bucket;
                        w_loc_re    = 1'b1;
                        w_loc_raddr = AW'(AW'(i_item.query_bucket) * AW'(SLOTS)
                                          + AW'(i_item.query_slot));
                        n_state     = S_WB;
                    end
                end
            end
            S_WB: begin
                if (r_is_query) begin
                    if (!w_out_busy) begin
                        n_ovalid = 1'b1;
                        n_ocount = OW'(w_qcnt);
                        n_oslot  = (CW'(r_qslot) < w_qcnt);
                        n_oloc   = (CW'(r_qslot) < w_qcnt) ? r_loc_rd : 32'd0;
                        n_state  = S_IDLE;
                    end
                end else begin
                    // count saturates one past the slot limit to mark overflow
                    w_cnt_we = (int'(w_cnt) <= SLOTS);
                    w_loc_we = (int'(w_cnt) < SLOTS);
                    n_state  = S_IDLE;
                end
            end
            S_CLEAR: begin
                w_cnt_we    = 1'b1;
                w_cnt_waddr = r_clr;
                w_cnt_wdata = '0;
                n_clr       = r_clr + 1'b1;
                if (r_clr == BW'(NBUCKETS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_cnt_re) begin
            r_cnt_rd <= cnt_mem[w_cnt_raddr];
        end
        if (w_cnt_we) begin
            cnt_mem[w_cnt_waddr] <= w_cnt_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_loc_re) begin
            r_loc_rd <= loc_mem[w_loc_raddr];
        end
        if (w_loc_we) begin
            loc_mem[w_loc_waddr] <= w_loc_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_wsize  <= WSIZE_RESET;
            r_epoch  <= '0;
            r_code   <= '0;
            r_run    <= '0;
            r_nloc   <= '0;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            if (i_cfg_we) begin
                r_wsize <= i_cfg_wdata;
            end
            r_epoch  <= n_epoch;
            r_code   <= n_code;
            r_run    <= n_run;
            r_nloc   <= n_nloc;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_query <= n_is_query;
        r_bucket   <= n_bucket;
        r_loc      <= n_loc;
        r_qslot    <= n_qslot;
        r_qin      <= n_qin;
        r_ocount   <= n_ocount;
        r_oloc     <= n_oloc;
        r_oslot    <= n_oslot;
    end

endmodule

@@ sv/kpi_checker.sv @@
// port-level checks for the k-mer position index, bound to the top level
module kpi_checker #(
    parameter int OW = 5
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          i_in_ready,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input logic [OW-1:0] i_out_count,
    input logic [31:0]   i_out_loc,
    input logic          i_out_slot_valid
);

    // item valid, item ready and result valid stay known once out of reset
    a_ctrl_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown({i_in_valid, i_in_ready, i_out_valid}))
        else $error("handshake control unknown");

    a_slot_needs_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_slot_valid |-> i_out_count != '0)
        else $error("valid slot reported for an empty bucket");

    a_invalid_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_slot_valid |-> i_out_loc == 32'd0)
        else $error("location nonzero on an invalid slot");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_count)
            && $stable(i_out_loc) && $stable(i_out_slot_valid))
        else $error("stalled result dropped or changed");

endmodule

bind kmer_position_index_core kpi_checker #(.OW(OW)) u_kpi_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_item.valid),
    .i_in_ready      (i_item.ready),
    .i_out_valid     (o_res.valid),
    .i_out_ready     (o_res.ready),
    .i_out_count     (o_res.bucket_count),
    .i_out_loc       (o_res.slot_location),
    .i_out_slot_valid(o_res.slot_valid)
);

@@ tb/kpi_index_checker.sv @@
// checker for the k-mer position index: watches both channels, predicts query replies, compares
module kpi_index_checker
    import kpi_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_wdata,
    kpi_in_if          i_item_mon,
    kpi_out_if         i_res_mon,
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_K = 6;
    localparam int SLOTS = 16;
    localparam int NBKT  = 1 << (2 * MAX_K);

    typedef struct packed {
        logic [4:0]  bucket_count;
        logic [31:0] slot_location;
        logic        slot_valid;
    } slot_reply_t;

    slot_reply_t slot_replies_due[$];

    logic [4:0]  tally [NBKT];
    logic [31:0] loc_mem [NBKT * SLOTS];
    logic [11:0] win_code;
    int unsigned run_len;
    logic [31:0] next_loc;
    logic [2:0]  wsize;
    int          fails = 0;

    function automatic int unsigned active_k();
        if (wsize == 3'd0)
            return 1;
        if (wsize > 3'(MAX_K))
            return MAX_K;
        return int'(wsize);
    endfunction

    // {ok, code}
    function automatic logic [2:0] decode_nucleotide(input logic [7:0] ch);
        case (ch)
            CH_A_UP, CH_A_LO: return {1'b1, CODE_A};
            CH_C_UP, CH_C_LO: return {1'b1, CODE_C};
            CH_G_UP, CH_G_LO: return {1'b1, CODE_G};
            CH_T_UP, CH_T_LO: return {1'b1, CODE_T};
            default:          return 3'b000;
        endcase
    endfunction

    task automatic clear_counts();
        foreach (tally[i])
            tally[i] = '0;
    endtask

    task automatic index_apply_item(input logic [1:0] mode, input logic [7:0] ch,
                                    input logic [31:0] start, input logic [11:0] bkt,
                                    input logic [3:0] slot);
        int unsigned k;
        int unsigned kmask;
        int unsigned b;
        int unsigned c;
        logic [2:0]  dec;
        slot_reply_t rep;
        k     = active_k();
        kmask = (1 << (2 * k)) - 1;
        case (mode)
            MODE_BEGIN: begin
                clear_counts();
                win_code = '0;
                run_len  = 0;
                next_loc = start;
            end
            MODE_BASE: begin
                dec = decode_nucleotide(ch);
                if (!dec[2]) begin
                    run_len = 0;
                end else begin
                    win_code = {win_code[9:0], dec[1:0]};
                    if (run_len < MAX_K)
                        run_len++;
                    if (run_len >= k) begin
                        b = win_code & kmask;
                        c = tally[b];
                        // window location is that of its first base
                        if (c < SLOTS)
                            loc_mem[b * SLOTS + c] = next_loc - 32'(k - 1);
                        if (c <= SLOTS)
                            tally[b] = 5'(c + 1);
                    end
                end
                next_loc = next_loc + 32'd1;
            end
            MODE_QUERY: begin
                rep = '0;
                b   = bkt;
                if (b <= kmask) begin
                    c = tally[b];
                    // an overflowed bucket reads as empty
                    rep.bucket_count = (c > SLOTS) ? 5'd0 : 5'(c);
                end
                if (slot < rep.bucket_count) begin
                    rep.slot_valid    = 1'b1;
                    rep.slot_location = loc_mem[b * SLOTS + slot];
                end
                slot_replies_due.push_back(rep);
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        slot_reply_t want;
        if (!i_rst_n) begin
            clear_counts();
            win_code = '0;
            run_len  = 0;
            next_loc = '0;
            wsize    = WSIZE_RESET;
            slot_replies_due.delete();
        end else begin
            // a result at this edge always belongs to an earlier query
            if (i_res_mon.valid && i_res_mon.ready) begin
                if (slot_replies_due.size() == 0) begin
                    $error("unexpected result: bucket_count %0d slot_location %0h slot_valid %0b",
                           i_res_mon.bucket_count, i_res_mon.slot_location,
                           i_res_mon.slot_valid);
                    fails++;
                end else begin
                    want = slot_replies_due.pop_front();
                    if (i_res_mon.bucket_count !== want.bucket_count) begin
                        $error("bucket_count: expected %0d, got %0d",
                               want.bucket_count, i_res_mon.bucket_count);
                        fails++;
                    end
                    if (i_res_mon.slot_location !== want.slot_location) begin
                        $error("slot_location: expected %0h, got %0h",
                               want.slot_location, i_res_mon.slot_location);
                        fails++;
                    end
                    if (i_res_mon.slot_valid !== want.slot_valid) begin
                        $error("slot_valid: expected %0b, got %0b",
                               want.slot_valid, i_res_mon.slot_valid);
                        fails++;
                    end
                end
            end
            if (i_cfg_we)
                wsize = i_cfg_wdata;
            if (i_item_mon.valid && i_item_mon.ready)
                index_apply_item(i_item_mon.mode, i_item_mon.base_char,
                                 i_item_mon.start_location, i_item_mon.query_bucket,
                                 i_item_mon.query_slot);
        end
        o_fail_count <= fails;
        o_pending    <= slot_replies_due.size();
    end

endmodule

@@ tb/tb_top.sv @@
// testbench top for the k-mer position index: clock, reset, stimulus and verdict
module tb_top
    import kpi_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [2:0] i_cfg_wdata;
    int         fail_count;
    int         pending;

    kpi_in_if  #(.BW(12), .SW(4)) item_ch ();
    kpi_out_if #(.CW(5))          res_ch ();

    kmer_position_index_core #(
        .MAX_K(6),
        .SLOTS(16)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_item     (item_ch),
        .o_res      (res_ch)
    );

    kpi_index_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item_mon  (item_ch),
        .i_res_mon   (res_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    bit          idle_on  = 1'b1;
    bit          hold_req = 1'b0;
    logic [11:0] hot_codes [8];
    int          hot_wr    = 0;
    logic [11:0] stim_win  = '0;
    int          stim_mask = 4095;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("kmer_position_index_core: mismatch");
        $finish;
    end

    // result side: random back-pressure, plus one long hold-off on request
    initial begin
        forever begin
            if (hold_req) begin
                res_ch.ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    function automatic logic [7:0] nucleotide_char(input logic [1:0] code, input bit lower);
        case (code)
            CODE_A:  return lower ? CH_A_LO : CH_A_UP;
            CODE_C:  return lower ? CH_C_LO : CH_C_UP;
            CODE_G:  return lower ? CH_G_LO : CH_G_UP;
            default: return lower ? CH_T_LO : CH_T_UP;
        endcase
    endfunction

    // returns at the edge where the transaction is taken; valid is left high
    task automatic send_item(input logic [1:0] mode, input logic [7:0] ch,
                             input logic [31:0] start, input logic [11:0] bkt,
                             input logic [3:0] slot);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        item_ch.valid          <= 1'b1;
        item_ch.mode           <= mode;
        item_ch.base_char      <= ch;
        item_ch.start_location <= start;
        item_ch.query_bucket   <= bkt;
        item_ch.query_slot     <= slot;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_begin(input logic [31:0] start);
        send_item(MODE_BEGIN, 8'($urandom), start, 12'($urandom), 4'($urandom));
    endtask

    task automatic send_byte(input logic [7:0] ch);
        send_item(MODE_BASE, ch, $urandom, 12'($urandom), 4'($urandom));
    endtask

    // remember recent window codes so queries land on filled buckets
    task automatic send_base(input logic [1:0] code);
        stim_win = {stim_win[9:0], code};
        hot_codes[hot_wr] = stim_win & 12'(stim_mask);
        hot_wr = (hot_wr + 1) % 8;
        send_byte(nucleotide_char(code, 1'($urandom)));
    endtask

    task automatic send_query(input logic [11:0] bkt, input logic [3:0] slot);
        send_item(MODE_QUERY, 8'($urandom), $urandom, bkt, slot);
    endtask

    task automatic send_query_random();
        logic [11:0] bkt;
        logic [3:0]  slot;
        case ($urandom_range(0, 3))
            0, 1:    bkt = hot_codes[$urandom_range(0, 7)];
            2:       bkt = 12'($urandom_range(0, stim_mask));
            default: bkt = 12'($urandom_range(0, 4095));
        endcase
        slot = $urandom_range(0, 1) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
        send_query(bkt, slot);
    endtask

    // a query as fence, drain all replies, then write the window size
    task automatic set_window(input logic [2:0] wsize);
        int k;
        send_query_random();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= wsize;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        k = (wsize == 3'd0) ? 1 : (wsize > 3'd6) ? 6 : int'(wsize);
        stim_mask = (1 << (2 * k)) - 1;
    endtask

    task automatic run_phase(input int n_items, input bit motif_mode);
        logic [1:0]  motif [8];
        logic [31:0] start;
        int          period;
        int          r;
        case ($urandom_range(0, 3))
            0:       start = 32'hFFFF_FFFF - 32'($urandom_range(0, 40));
            1:       start = 32'h0;
            default: start = $urandom;
        endcase
        send_begin(start);
        period = $urandom_range(1, 8);
        foreach (motif[j])
            motif[j] = 2'($urandom);
        for (int i = 0; i < n_items; i++) begin
            r = $urandom_range(0, 99);
            if (r < 60)
                send_base(motif_mode ? motif[i % period] : 2'($urandom));
            else if (r < 70)
                send_byte(8'($urandom_range(0, 255)));
            else if (r < 97)
                send_query_random();
            else if (r < 99)
                send_begin($urandom);
            else
                send_item(MODE_UNUSED, 8'($urandom), $urandom, 12'($urandom), 4'($urandom));
        end
    endtask

    initial begin
        logic [2:0] ksched [8];
        ksched = '{3'd1, 3'd6, 3'd0, 3'd7, 3'd3, 3'd2, 3'd5, 3'd4};
        foreach (hot_codes[j])
            hot_codes[j] = '0;
        i_rst_n                <= 1'b0;
        i_cfg_we               <= 1'b0;
        i_cfg_wdata            <= '0;
        item_ch.valid          <= 1'b0;
        item_ch.mode           <= MODE_BEGIN;
        item_ch.base_char      <= '0;
        item_ch.start_location <= '0;
        item_ch.query_bucket   <= '0;
        item_ch.query_slot     <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: default window of six, locations that wrap
        send_query(12'd0, 4'd0);
        send_begin(32'hFFFF_FFFD);
        send_byte(CH_A_UP);
        send_byte(CH_C_UP);
        send_byte(CH_G_UP);
        send_byte(CH_T_UP);
        send_byte(CH_A_LO);
        send_byte(CH_C_LO);
        send_byte(CH_G_LO);
        send_byte(CH_T_LO);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h4E);
        send_query(12'h1B1, 4'd0);
        send_query(12'h1B1, 4'd1);
        send_query(12'hB1B, 4'd0);
        send_query(12'hFFF, 4'hF);
        send_item(MODE_UNUSED, 8'hFF, 32'hFFFF_FFFF, 12'hFFF, 4'hF);

        // window size zero behaves as one
        set_window(3'd0);
        send_query(12'd4, 4'd0);
        send_byte(CH_G_LO);
        send_byte(CH_G_UP);
        send_byte(8'h78);
        send_byte(CH_G_LO);
        send_query(12'd2, 4'd2);
        send_query(12'd2, 4'd3);

        for (int p = 0; p < 8; p++) begin
            set_window(ksched[p]);
            if (p == 1)
                hold_req = 1'b1;
            if (p == 7)
                idle_on = 1'b0;
            run_phase(85, p[0]);
        end

        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("kmer_position_index_core: match");
        else
            $display("kmer_position_index_core: mismatch");
        $finish;
    end

endmodule

@@ files.f @@
sv/kpi_pkg.sv
sv/kpi_if.sv
sv/kmer_position_index_core.sv
sv/kpi_checker.sv
tb/kpi_index_checker.sv
tb/tb_top.sv
